>>> hw/rtl/qpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_pkg
// Types and constants shared by the quadrature position PID block.
// ----------------------------------------------------------------------------
package qpp_pkg;

    localparam int TARGET_REGS = 3;
    localparam int POS_W       = 24;
    localparam int ERR_W       = POS_W + 1;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 40;
    localparam int GAIN_W      = 16;
    localparam int VAL_W       = 57;
    localparam int PADDR_W     = 5;

    localparam logic signed [POS_W-1:0] DEFAULT_TARGET = -24'sd400;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic KIND_ENC  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_TGT0 = 3'd3,
        REG_TGT1 = 3'd4,
        REG_TGT2 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]          kp;
        logic [GAIN_W-1:0]          ki;
        logic [GAIN_W-1:0]          kd;
        pos_t [TARGET_REGS-1:0]     target;
    } cfg_t;

    // one motor's entry in the state memory
    typedef struct packed {
        pos_t count;
        sum_t sum;
        err_t prev;
    } motor_state_t;

    // control tick leaving the read-modify-write stage
    typedef struct packed {
        logic       valid;
        logic [1:0] motor;
        err_t       e;
        sum_t       sum;
        diff_t      d;
        pos_t       position;
    } tick_t;

endpackage
`default_nettype wire

>>> hw/rtl/qpp_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_item_if
// Input channel: encoder changes and control ticks.
// ----------------------------------------------------------------------------
interface qpp_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] motor;
    logic       phase_a;
    logic       phase_b;

    modport source (output valid, kind, motor, phase_a, phase_b, input ready);
    modport sink   (input valid, kind, motor, phase_a, phase_b, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/qpp_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_result_if
// Output channel: motor drive words.
// ----------------------------------------------------------------------------
interface qpp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  motor_out;
    logic        forward;
    logic [7:0]  duty;
    logic [23:0] position;

    modport source (output valid, motor_out, forward, duty, position, input ready);
    modport sink   (input valid, motor_out, forward, duty, position, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/qpp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/qpp_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_regs
// APB-style register file holding the PID gains and the motor targets.
// ----------------------------------------------------------------------------
module qpp_regs import qpp_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_KP:   cfg_next.kp        = pwdata[GAIN_W-1:0];
                REG_KI:   cfg_next.ki        = pwdata[GAIN_W-1:0];
                REG_KD:   cfg_next.kd        = pwdata[GAIN_W-1:0];
                REG_TGT0: cfg_next.target[0] = pwdata[POS_W-1:0];
                REG_TGT1: cfg_next.target[1] = pwdata[POS_W-1:0];
                REG_TGT2: cfg_next.target[2] = pwdata[POS_W-1:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KP:   prdata = {16'd0, cfg_reg.kp};
            REG_KI:   prdata = {16'd0, cfg_reg.ki};
            REG_KD:   prdata = {16'd0, cfg_reg.kd};
            REG_TGT0: prdata = {{8{cfg_reg.target[0][POS_W-1]}}, cfg_reg.target[0]};
            REG_TGT1: prdata = {{8{cfg_reg.target[1][POS_W-1]}}, cfg_reg.target[1]};
            REG_TGT2: prdata = {{8{cfg_reg.target[2][POS_W-1]}}, cfg_reg.target[2]};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp     <= 16'd2304;
            cfg_reg.ki     <= 16'd26;
            cfg_reg.kd     <= 16'd3584;
            cfg_reg.target <= {TARGET_REGS{DEFAULT_TARGET}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/qpp_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_state
// Per-motor state memory with read-modify-write: counts encoder changes,
// forms the error, the saturating integral and the error difference for control ticks.
// ----------------------------------------------------------------------------
module qpp_state import qpp_pkg::*; #(
    parameter int MOTORS = 3
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       take,
    input  wire logic       kind,
    input  wire logic [1:0] motor,
    input  wire logic       up,
    input  cfg_t            cfg,
    output tick_t           tick
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic [1:0]    s1_motor_reg;
    logic          s1_up_reg;
    logic [AW-1:0] s1_addr_reg;

    logic              wb_valid_reg;
    logic [AW-1:0]     wb_addr_reg;
    motor_state_t      wb_reg;
    logic [MOTORS-1:0] live_reg;
    logic [MOTORS-1:0] live_next;

    logic [$bits(motor_state_t)-1:0] rdata;
    logic [AW-1:0]                   raddr;
    motor_state_t cur;
    motor_state_t nxt;
    pos_t         tgt;
    err_t         e;
    logic signed [SUM_W:0] sum_wide;
    sum_t         sum_sat;
    diff_t        d;
    logic         we;

    assign raddr = AW'(motor);
    assign we    = s1_valid_reg && adv;

    qpp_ram #(
        .WIDTH ($bits(motor_state_t)),
        .DEPTH (MOTORS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_addr_reg),
        .wdata (nxt),
        .re    (adv),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        // newest write wins over memory; an untouched entry reads as zero
        if (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
        begin
            cur = wb_reg;
        end
        else if (live_reg[s1_addr_reg])
        begin
            cur = motor_state_t'(rdata);
        end
        else
        begin
            cur = '0;
        end

        if (s1_motor_reg < 2'(TARGET_REGS))
        begin
            tgt = cfg.target[s1_motor_reg];
        end
        else
        begin
            tgt = DEFAULT_TARGET;
        end

        e        = {cur.count[POS_W-1], cur.count} - {tgt[POS_W-1], tgt};
        sum_wide = {cur.sum[SUM_W-1], cur.sum} + {{(SUM_W+1-ERR_W){e[ERR_W-1]}}, e};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        d = {e[ERR_W-1], e} - {cur.prev[ERR_W-1], cur.prev};

        nxt = cur;
        if (s1_kind_reg == KIND_ENC)
        begin
            nxt.count = s1_up_reg ? cur.count + 24'sd1 : cur.count - 24'sd1;
        end
        else
        begin
            nxt.sum  = sum_sat;
            nxt.prev = e;
        end

        tick.valid    = s1_valid_reg && (s1_kind_reg == KIND_TICK);
        tick.motor    = s1_motor_reg;
        tick.e        = e;
        tick.sum      = sum_sat;
        tick.d        = d;
        tick.position = cur.count;

        live_next = live_reg;
        if (we)
        begin
            live_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            live_reg     <= '0;
        end
        else
        begin
            live_reg <= live_next;
            if (adv)
            begin
                s1_valid_reg <= take;
            end
            if (we)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg  <= kind;
            s1_motor_reg <= motor;
            s1_up_reg    <= up;
            s1_addr_reg  <= raddr;
        end
        if (we)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_reg      <= nxt;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/qpp_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_calc
// PID products, their sum, and the drive word register.
// ----------------------------------------------------------------------------
module qpp_calc import qpp_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  tick_t       tick,
    input  cfg_t        cfg,
    output logic        adv,
    qpp_result_if.source result
);

    localparam int PP_W = GAIN_W + 1 + ERR_W;
    localparam int PI_W = GAIN_W + 1 + SUM_W;
    localparam int PD_W = GAIN_W + 1 + DIFF_W;

    // register the tick so the multipliers start from flops
    tick_t                  tick_reg;

    logic                   p2_valid_reg;
    logic [1:0]             p2_motor_reg;
    pos_t                   p2_pos_reg;
    logic signed [PP_W-1:0] pp_reg;
    logic signed [PI_W-1:0] pi_reg;
    logic signed [PD_W-1:0] pd_reg;

    logic                    p3_valid_reg;
    logic [1:0]              p3_motor_reg;
    pos_t                    p3_pos_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic signed [VAL_W-1:0] v_next;

    logic                    out_valid_reg;
    logic [1:0]              out_motor_reg;
    logic                    out_fwd_reg;
    logic [7:0]              out_duty_reg;
    pos_t                    out_pos_reg;

    logic [VAL_W-1:0] mag;
    logic [7:0]       duty_next;

    assign adv = !out_valid_reg || result.ready;

    assign v_next = VAL_W'(pp_reg) + VAL_W'(pi_reg) + VAL_W'(pd_reg);

    always_comb
    begin
        mag = v_reg[VAL_W-1] ? -v_reg : v_reg;
        // saturate |v| >> 8 to eight bits
        if (|mag[VAL_W-1:16])
        begin
            duty_next = 8'hFF;
        end
        else
        begin
            duty_next = mag[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tick_reg      <= tick;
            p2_valid_reg  <= tick_reg.valid;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_motor_reg  <= tick_reg.motor;
            p2_pos_reg    <= tick_reg.position;
            pp_reg        <= signed'({1'b0, cfg.kp}) * tick_reg.e;
            pi_reg        <= signed'({1'b0, cfg.ki}) * tick_reg.sum;
            pd_reg        <= signed'({1'b0, cfg.kd}) * tick_reg.d;
            p3_motor_reg  <= p2_motor_reg;
            p3_pos_reg    <= p2_pos_reg;
            v_reg         <= v_next;
            out_motor_reg <= p3_motor_reg;
            out_pos_reg   <= p3_pos_reg;
            out_fwd_reg   <= !v_reg[VAL_W-1];
            out_duty_reg  <= duty_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.motor_out = out_motor_reg;
    assign result.forward   = out_fwd_reg;
    assign result.duty      = out_duty_reg;
    assign result.position  = out_pos_reg;

endmodule
`default_nettype wire

>>> hw/rtl/quadrature_position_pid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_position_pid
// Quadrature position counter and position PID for several motors.
// ----------------------------------------------------------------------------
// The block takes one word per cycle on the item channel, encoder changes and
// control ticks mixed in any order, and returns one drive word per control
// tick through the state, tick, product, sum and drive word registers.
// Per-motor state (count, integral, previous error) lives in a small RAM read
// as an item is taken and written back as it leaves the state stage; the last
// write is forwarded, so repeated items for the same motor still flow at one
// per cycle. The whole pipeline holds while a drive word waits on the result
// channel. Reset marks every motor entry as zero at once; there is no
// clearing pass. Items for a motor at or above MOTORS are taken and dropped.
// ----------------------------------------------------------------------------
module quadrature_position_pid import qpp_pkg::*; #(
    parameter int MOTORS = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    qpp_item_if.sink                item,
    qpp_result_if.source            result
);

    cfg_t  cfg;
    tick_t tick;
    logic  adv;
    logic  take;

    assign item.ready = adv;
    assign take = item.valid && (32'(item.motor) < 32'(MOTORS));

    qpp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qpp_state #(
        .MOTORS (MOTORS)
    ) u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .take  (take),
        .kind  (item.kind),
        .motor (item.motor),
        .up    (item.phase_a == item.phase_b),
        .cfg   (cfg),
        .tick  (tick)
    );

    qpp_calc u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cfg    (cfg),
        .adv    (adv),
        .result (result)
    );

endmodule
`default_nettype wire

>>> hw/rtl/qpp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpp_checker
// Port-level checks for the quadrature position PID block.
// ----------------------------------------------------------------------------
module qpp_checker import qpp_pkg::*; #(
    parameter int MOTORS = 3
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [PADDR_W-1:0] paddr,
    input wire logic [31:0]        pwdata,
    input wire logic [31:0]        prdata,
    input wire logic               item_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic [1:0]         res_motor,
    input wire logic               res_forward,
    input wire logic [7:0]         res_duty,
    input wire logic [23:0]        res_position
);

    // hold a stalled drive word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_motor)
            && $stable(res_forward) && $stable(res_duty) && $stable(res_position))
        else $error("drive word changed while stalled");

    a_motor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (32'(res_motor) < 32'(MOTORS)))
        else $error("drive word for a motor that does not exist");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("input held while output stage empty");

    a_kp_back: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_KP))
        |=> ((paddr[PADDR_W-1:2] == REG_KP) |-> (prdata[15:0] == $past(pwdata[15:0]))))
        else $error("kp readback mismatch");

endmodule

bind quadrature_position_pid qpp_checker #(.MOTORS(MOTORS)) u_qpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .item_ready   (item.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_motor    (result.motor_out),
    .res_forward  (result.forward),
    .res_duty     (result.duty),
    .res_position (result.position)
);
`default_nettype wire
